### sv/awedb_pkg.sv
// shared types, constants and codes for the audio window energy meter
package awedb_pkg;

    localparam int HISTORY_DEPTH = 1024;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);

    localparam int SAMPLE_W  = 16;
    localparam int SQ_W      = 31;
    localparam int SUM_W     = 40;
    localparam int WLEN_W    = 9;
    localparam int FLOOR_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 9'd40;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 7'd90;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_DB      = 2'd1;

    // log2 in Q.16: 6 bit exponent, 16 bit fraction
    localparam int LG_W       = 22;
    localparam int LOG_ROUNDS = 16;
    localparam int RND_W      = $clog2(LOG_ROUNDS);
    localparam logic [SUM_W-1:0] X_TOP = SUM_W'(SUM_W - 1);
    localparam logic [23:0] LOG_BIAS = 24'd30 << 16;

    // 10*log10(2) in Q.24
    localparam logic [25:0] DB_COEF = 26'd50504453;
    localparam int DBMAG_W = 15;

    localparam int DVD_W     = 21;
    localparam int DIV_STEPS = DVD_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [15:0] NORM_TMAX = 16'd49152;
    localparam logic [16:0] NORM_ONE  = 17'd16384;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_CLASSIFY,
        ST_LOG_NORM,
        ST_LOG_MUL,
        ST_LOG_ADJ,
        ST_LOG_END,
        ST_DB_SUB,
        ST_DB_MUL,
        ST_DB_RND,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic square;
        logic accum;
        logic log_load_sum;
        logic log_load_n;
        logic log_norm;
        logic log_mul;
        logic log_adj;
        logic lg_store;
        logic db_sub;
        logic db_mul;
        logic db_rnd;
        logic db_floor;
        logic db_zero;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic win_done;
        logic sum_zero;
        logic sum_full;
        logic log_norm_done;
        logic log_last;
        logic log_on_n;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

### sv/awedb_if.sv
// request channels: sample in, level result out, register writes
interface awedb_in_if;
    import awedb_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface awedb_out_if;
    import awedb_pkg::*;
    logic                valid;
    logic                ready;
    logic signed [15:0]  energy_db;
    logic signed [15:0]  energy_norm;
    logic [SLOT_W-1:0]   slot_index;
    logic                pass_complete;
    modport source (output valid, output energy_db, output energy_norm,
                    output slot_index, output pass_complete, input ready);
    modport sink (input valid, input energy_db, input energy_norm,
                  input slot_index, input pass_complete, output ready);
endinterface

interface awedb_cfg_if;
    import awedb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/awedb_ctrl.sv
// sequencer for accumulate, log2, dB scaling and normalize divide
module awedb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  awedb_pkg::status_t status,
    output awedb_pkg::cmd_t    cmd
);
    import awedb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = status.win_done ? ST_CLASSIFY : ST_IDLE;
            end
            ST_CLASSIFY:
            begin
                if (status.sum_zero)
                begin
                    cmd.db_floor = 1'b1;
                    state_next   = ST_DIV_INIT;
                end
                else if (status.sum_full)
                begin
                    cmd.db_zero = 1'b1;
                    state_next  = ST_DIV_INIT;
                end
                else
                begin
                    cmd.log_load_sum = 1'b1;
                    state_next       = ST_LOG_NORM;
                end
            end
            ST_LOG_NORM:
            begin
                cmd.log_norm = 1'b1;
                if (status.log_norm_done)
                begin
                    state_next = ST_LOG_MUL;
                end
            end
            ST_LOG_MUL:
            begin
                cmd.log_mul = 1'b1;
                state_next  = ST_LOG_ADJ;
            end
            ST_LOG_ADJ:
            begin
                cmd.log_adj = 1'b1;
                state_next  = status.log_last ? ST_LOG_END : ST_LOG_MUL;
            end
            ST_LOG_END:
            begin
                if (status.log_on_n)
                begin
                    state_next = ST_DB_SUB;
                end
                else
                begin
                    // keep lg(sum), then run the same unit on the window length
                    cmd.lg_store   = 1'b1;
                    cmd.log_load_n = 1'b1;
                    state_next     = ST_LOG_NORM;
                end
            end
            ST_DB_SUB:
            begin
                cmd.db_sub = 1'b1;
                state_next = ST_DB_MUL;
            end
            ST_DB_MUL:
            begin
                cmd.db_mul = 1'b1;
                state_next = ST_DB_RND;
            end
            ST_DB_RND:
            begin
                cmd.db_rnd = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV_STEP;
            end
            ST_DIV_STEP:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/awedb_dp.sv
// datapath: square-sum, log2 by repeated squaring, dB multiply, divider
module awedb_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  awedb_pkg::cmd_t    cmd,
    output awedb_pkg::status_t status,
    awedb_in_if.sink           audio,
    awedb_out_if.source        level,
    awedb_cfg_if.sink          cfg
);
    import awedb_pkg::*;

    logic [WLEN_W-1:0]  wlen_reg;
    logic [FLOOR_W-1:0] floor_reg;
    logic [WLEN_W-1:0]  n_eff;
    logic [FLOOR_W-1:0] f_eff;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [31:0]         sq_prod;
    logic [SQ_W-1:0]            sq_reg;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [WLEN_W-1:0]          cnt_reg, cnt_next;
    logic [WLEN_W:0]            cnt_inc;
    logic [SLOT_W-1:0]          slot_reg, slot_next;
    logic                       slot_wrap;

    logic [SUM_W-1:0]   x_reg, x_next;
    logic [5:0]         e_reg, e_next;
    logic [31:0]        m_reg, m_next;
    logic [15:0]        frac_reg, frac_next;
    logic [63:0]        prod_reg, prod_next;
    logic [RND_W-1:0]   rnd_reg, rnd_next;
    logic               on_n_reg, on_n_next;
    logic [LG_W-1:0]    lg_sum_reg;
    logic [LG_W-1:0]    negl_reg;
    logic [23:0]        negl_diff;
    logic [47:0]        db_round;
    logic [DBMAG_W-1:0] dbmag_reg, dbmag_next;

    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [FLOOR_W-1:0] rem_reg, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [FLOOR_W:0]   rem_sh;
    logic               rem_ge;

    logic [15:0]        t_clamp;
    logic               out_valid_reg;
    logic signed [15:0] db_out_reg;
    logic signed [15:0] norm_out_reg;
    logic [SLOT_W-1:0]  slot_out_reg;
    logic               pass_out_reg;

    assign n_eff   = (wlen_reg == '0) ? WLEN_W'(1) : wlen_reg;
    assign f_eff   = (floor_reg == '0) ? FLOOR_W'(1) : floor_reg;
    assign sq_prod = sample_reg * sample_reg;
    assign cnt_inc = {1'b0, cnt_reg} + 1'b1;

    assign slot_wrap = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1));
    assign slot_next = slot_wrap ? '0 : slot_reg + 1'b1;

    // L > 0 is clamped, so only the positive part of -L is kept
    assign negl_diff = {2'b00, e_reg, frac_reg} + LOG_BIAS - {2'b00, lg_sum_reg};
    assign db_round  = prod_reg[47:0] + 48'h0000_8000_0000;

    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, f_eff});

    assign t_clamp = (dvd_reg > DVD_W'(NORM_TMAX)) ? NORM_TMAX : dvd_reg[15:0];

    assign audio.ready = cmd.in_ready;
    assign cfg.ready   = 1'b1;

    assign level.valid         = out_valid_reg;
    assign level.energy_db     = db_out_reg;
    assign level.energy_norm   = norm_out_reg;
    assign level.slot_index    = slot_out_reg;
    assign level.pass_complete = pass_out_reg;

    assign status.in_valid      = audio.valid;
    assign status.win_done      = (cnt_inc >= {1'b0, n_eff});
    assign status.sum_zero      = (sum_reg == '0);
    assign status.sum_full      = (sum_reg >= {1'b0, n_eff, 30'b0});
    assign status.log_norm_done = x_reg[SUM_W-1];
    assign status.log_last      = (rnd_reg == RND_W'(LOG_ROUNDS - 1));
    assign status.log_on_n      = on_n_reg;
    assign status.div_last      = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign status.out_free      = !out_valid_reg || level.ready;

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        if (cmd.accum)
        begin
            sum_next = sum_reg + SUM_W'(sq_reg);
            cnt_next = cnt_inc[WLEN_W-1:0];
        end
        else if (cmd.out_load)
        begin
            sum_next = '0;
            cnt_next = '0;
        end
    end

    // log2 unit: normalize one bit a cycle, then multiply / adjust rounds
    always_comb
    begin
        x_next    = x_reg;
        e_next    = e_reg;
        m_next    = m_reg;
        frac_next = frac_reg;
        prod_next = prod_reg;
        rnd_next  = rnd_reg;
        on_n_next = on_n_reg;
        if (cmd.log_load_sum)
        begin
            x_next    = sum_reg;
            e_next    = X_TOP[5:0];
            on_n_next = 1'b0;
        end
        else if (cmd.log_load_n)
        begin
            x_next    = SUM_W'(n_eff);
            e_next    = X_TOP[5:0];
            on_n_next = 1'b1;
        end
        else if (cmd.log_norm)
        begin
            if (x_reg[SUM_W-1])
            begin
                m_next    = x_reg[SUM_W-1 -: 32];
                frac_next = '0;
                rnd_next  = '0;
            end
            else
            begin
                x_next = {x_reg[SUM_W-2:0], 1'b0};
                e_next = e_reg - 1'b1;
            end
        end
        if (cmd.log_mul)
        begin
            prod_next = {32'b0, m_reg} * {32'b0, m_reg};
        end
        else if (cmd.db_mul)
        begin
            prod_next = {16'b0, 48'(negl_reg) * 48'(DB_COEF)};
        end
        if (cmd.log_adj)
        begin
            rnd_next = rnd_reg + 1'b1;
            if (prod_reg[63])
            begin
                m_next    = prod_reg[63:32];
                frac_next = {frac_reg[14:0], 1'b1};
            end
            else
            begin
                m_next    = prod_reg[62:31];
                frac_next = {frac_reg[14:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        dbmag_next = dbmag_reg;
        if (cmd.db_floor)
        begin
            dbmag_next = {f_eff, 8'b0};
        end
        else if (cmd.db_zero)
        begin
            dbmag_next = '0;
        end
        else if (cmd.db_rnd)
        begin
            dbmag_next = db_round[32 +: DBMAG_W];
        end
    end

    // restoring divider, quotient shifts into the dividend register
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;
        if (cmd.div_load)
        begin
            dvd_next  = {dbmag_reg, 6'b0} + DVD_W'(f_eff >> 1);
            rem_next  = '0;
            dcnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            dvd_next  = {dvd_reg[DVD_W-2:0], rem_ge};
            rem_next  = rem_ge ? FLOOR_W'(rem_sh - {1'b0, f_eff}) : rem_sh[FLOOR_W-1:0];
            dcnt_next = dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= WLEN_RESET;
            floor_reg     <= FLOOR_RESET;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            on_n_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_WINDOW_LENGTH: wlen_reg  <= cfg.data[WLEN_W-1:0];
                    CFG_FLOOR_DB:      floor_reg <= cfg.data[FLOOR_W-1:0];
                    default:           ;
                endcase
            end
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            on_n_reg <= on_n_next;
            if (cmd.out_load)
            begin
                slot_reg      <= slot_next;
                out_valid_reg <= 1'b1;
            end
            else if (level.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_ready && audio.valid)
        begin
            sample_reg <= audio.sample;
        end
        if (cmd.square)
        begin
            sq_reg <= sq_prod[SQ_W-1:0];
        end
        x_reg     <= x_next;
        e_reg     <= e_next;
        m_reg     <= m_next;
        frac_reg  <= frac_next;
        prod_reg  <= prod_next;
        rnd_reg   <= rnd_next;
        dbmag_reg <= dbmag_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        if (cmd.lg_store)
        begin
            lg_sum_reg <= {e_reg, frac_reg};
        end
        if (cmd.db_sub)
        begin
            negl_reg <= negl_diff[23] ? '0 : negl_diff[LG_W-1:0];
        end
        if (cmd.out_load)
        begin
            db_out_reg   <= 16'd0 - {1'b0, dbmag_reg};
            norm_out_reg <= 16'(NORM_ONE - {1'b0, t_clamp});
            slot_out_reg <= slot_reg;
            pass_out_reg <= slot_wrap;
        end
    end

endmodule

### sv/audio_window_energy_db_meter.sv
// top level: window mean-square level meter with dB and normalized output
//
//  channel | dir | payload                                          | request
//  audio   | in  | sample                                           | one sample
//  level   | out | energy_db, energy_norm, slot_index, pass_complete| one window
//  cfg     | in  | index, data                                      | one register
//
//  a sample that does not close its window runs accept, square and add
//  closing a window adds the result pass: classify, log2 of the sum and of the window
//  length (a load, normalize shifts, multiply/adjust rounds and an end step each),
//  dB subtract, multiply and round, the divider load and steps, and the output load;
//  a zero or full-scale window goes straight from classify to the divider
//  the finished result waits in an output register; a stall there holds the
//  sequencer only at the load, after the whole result pass is done
//  reset clears the sum, count and slot at once; cfg is always ready
module audio_window_energy_db_meter (
    input  logic        clk,
    input  logic        rst_n,
    awedb_in_if.sink    audio,
    awedb_out_if.source level,
    awedb_cfg_if.sink   cfg
);
    import awedb_pkg::*;

    cmd_t    cmd;
    status_t status;

    awedb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    awedb_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .audio  (audio),
        .level  (level),
        .cfg    (cfg)
    );

    // a result is never loaded over one that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!level.valid || level.ready))
        else $error("result overwritten before it was taken");

    // a new result shows up only right after the sequencer loads it
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(level.valid) |-> $past(cmd.out_load))
        else $error("result valid without a load");

    // no sample is taken during the log2 normalize, adjust or divider steps of the result pass
    assert property (@(posedge clk) disable iff (!rst_n)
        audio.ready |-> !(cmd.div_step || cmd.log_adj || cmd.log_norm))
        else $error("sample accepted during result pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (audio.valid && audio.ready) |=> cmd.square)
        else $error("accepted sample not squared next cycle");

endmodule

### bench/audio_window_energy_db_meter_tb.sv
// self-checking bench for the window energy dB meter: directed table, then random phases
module audio_window_energy_db_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import awedb_pkg::*;

    localparam int      CLK_PERIOD      = 10;
    localparam int      SETTLE_CYCLES   = 32;
    localparam int      TAIL_CYCLES     = 250;
    localparam int      DRAIN_LIMIT     = 20000;
    localparam int      HOLD_OFF_CYCLES = 400;
    localparam int      RAND_ITEMS      = 600;
    localparam int      QUIET_ITEMS     = 80;
    localparam int      MIN_LEVELS      = 48;
    localparam int      MAX_REPORTS     = 10;
    localparam longint  WATCHDOG_NS     = 10_000_000;
    // 10*log10(2) in Q.24
    localparam longint  DB_PER_OCTAVE_Q24 = 50504453;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    typedef struct packed {
        logic signed [15:0] db;
        logic signed [15:0] norm;
        logic [SLOT_W-1:0]  slot;
        logic               wrap;
    } level_t;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          val;
        logic                 typed;
        logic [15:0]          db;
        logic [15:0]          norm;
    } step_row_t;

    // typed rows carry db and norm that follow directly from the window contents
    step_row_t directed_rows [35] = '{
        '{ROW_CFG,    CFG_WINDOW_LENGTH, 16'd1,     1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0000,  1'b1, -16'sd23040,  16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h8000,  1'b1, 16'd0,        16'd16384},
        '{ROW_SAMPLE, 2'd0,              16'h7FFF,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0001,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'hFFFF,  1'b0, 16'd0,        16'd0},
        '{ROW_CFG,    CFG_FLOOR_DB,      16'd120,   1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0000,  1'b1, -16'sd30720,  16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0001,  1'b0, 16'd0,        16'd0},
        '{ROW_CFG,    CFG_FLOOR_DB,      16'd1,     1'b0, 16'd0,        16'd0},
        // norm saturates at the bottom here
        '{ROW_SAMPLE, 2'd0,              16'h0001,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0000,  1'b1, -16'sd256,    16'd0},
        // floor of zero behaves as one, upper data bits dropped
        '{ROW_CFG,    CFG_FLOOR_DB,      16'h0180,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0000,  1'b1, -16'sd256,    16'd0},
        '{ROW_CFG,    CFG_UNMAPPED_LO,   16'h01FF,  1'b0, 16'd0,        16'd0},
        '{ROW_CFG,    CFG_UNMAPPED_HI,   16'h0000,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0000,  1'b1, -16'sd256,    16'd0},
        '{ROW_CFG,    CFG_FLOOR_DB,      16'd90,    1'b0, 16'd0,        16'd0},
        '{ROW_CFG,    CFG_WINDOW_LENGTH, 16'd0,     1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h8000,  1'b1, 16'd0,        16'd16384},
        // long window, then cut short below the running count
        '{ROW_CFG,    CFG_WINDOW_LENGTH, 16'd511,   1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h4000,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'hC000,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0064,  1'b0, 16'd0,        16'd0},
        '{ROW_CFG,    CFG_WINDOW_LENGTH, 16'd2,     1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0000,  1'b0, 16'd0,        16'd0},
        '{ROW_CFG,    CFG_WINDOW_LENGTH, 16'd3,     1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0000,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0000,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h0000,  1'b1, -16'sd23040,  16'd0},
        '{ROW_CFG,    CFG_WINDOW_LENGTH, 16'd2,     1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h8000,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h7FFF,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h8000,  1'b0, 16'd0,        16'd0},
        '{ROW_SAMPLE, 2'd0,              16'h8000,  1'b1, 16'd0,        16'd16384}
    };

    logic clk = 1'b0;
    logic rst_n;

    awedb_in_if  audio ();
    awedb_out_if level ();
    awedb_cfg_if cfg ();

    audio_window_energy_db_meter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .audio (audio),
        .level (level),
        .cfg   (cfg)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // meter state as the bench sees it
    logic [WLEN_W-1:0]  win_len_reg;
    logic [FLOOR_W-1:0] floor_reg;
    logic [SUM_W-1:0]   acc_sq;
    logic [WLEN_W-1:0]  acc_count;
    int                 slot_no;

    level_t levels_due [$];

    int error_count       = 0;
    int samples_sent      = 0;
    int levels_predicted  = 0;
    int levels_checked    = 0;
    int wraps_seen        = 0;
    int reg_writes        = 0;
    int max_window        = 0;
    int hold_off_req      = 0;
    int longest_hold      = 0;
    bit quiet             = 1'b0;
    bit calm              = 1'b0;

    // log2 in Q.16 by repeated squaring of the normalized mantissa
    function automatic longint octave_log_q16(input longint x);
        int              e;
        int              i;
        longint unsigned m;
        longint          fr;
        e = 0;
        fr = 0;
        while (e < 63 && (x >> (e + 1)) != 0)
            e++;
        if (e >= 31)
            m = x >> (e - 31);
        else
            m = x << (31 - e);
        for (i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000)
            begin
                fr = fr | 1;
                m = m >> 1;
            end
        end
        return longint'(e) * 65536 + fr;
    endfunction

    function automatic bit meter_sample(input logic signed [15:0] s, output level_t lv);
        longint sq;
        longint total;
        longint n;
        longint f;
        longint l;
        longint db;
        longint t;
        int     next_slot;
        lv = '0;
        sq = longint'(s) * longint'(s);
        acc_sq = acc_sq + SUM_W'(sq);
        acc_count = acc_count + 1'b1;
        n = (win_len_reg == 0) ? 1 : longint'(win_len_reg);
        f = (floor_reg == 0) ? 1 : longint'(floor_reg);
        if (longint'(acc_count) < n)
            return 1'b0;

        total = longint'(acc_sq);
        if (total == 0)
            db = -f * 256;
        else if (total >= (n << 30))
            db = 0;
        else
        begin
            l = octave_log_q16(total) - octave_log_q16(n) - 30 * 65536;
            if (l > 0)
                l = 0;
            db = -(((-l) * DB_PER_OCTAVE_Q24 + (longint'(1) << 31)) >> 32);
        end
        t = (-db * 64 + f / 2) / f;
        if (t > 49152)
            t = 49152;

        next_slot = (slot_no + 1) % HISTORY_DEPTH;
        lv.db   = db[15:0];
        lv.norm = 16'(16384 - t);
        lv.slot = slot_no[SLOT_W-1:0];
        lv.wrap = (next_slot == 0);
        slot_no = next_slot;
        acc_sq = '0;
        acc_count = '0;
        return 1'b1;
    endfunction

    // only while the meter is idle: all levels in, then a short settle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        audio.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_WINDOW_LENGTH)
        begin
            win_len_reg = val;
            if (int'(val) > max_window)
                max_window = int'(val);
        end
        else if (idx == CFG_FLOOR_DB)
            floor_reg = val[FLOOR_W-1:0];
    endtask

    task automatic send_sample(input logic signed [15:0] s, input logic typed,
                               input logic signed [15:0] typed_db,
                               input logic signed [15:0] typed_norm);
        level_t lv;
        if (!quiet && !calm && $urandom_range(0, 4) == 0)
        begin
            audio.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        audio.valid  <= 1'b1;
        audio.sample <= s;
        @(posedge clk);
        while (!audio.ready)
            @(posedge clk);
        samples_sent++;
        if (meter_sample(s, lv))
        begin
            if (typed)
            begin
                lv.db   = typed_db;
                lv.norm = typed_norm;
            end
            levels_due.push_back(lv);
            levels_predicted++;
        end
    endtask

    initial begin : level_sink
        int     stall_left;
        level_t want;
        stall_left = 0;
        level.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (level.valid && level.ready)
            begin
                if (levels_due.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected level: db %0d norm %0d slot %0d wrap %0b",
                                 level.energy_db, level.energy_norm,
                                 level.slot_index, level.pass_complete);
                    error_count++;
                end
                else
                begin
                    want = levels_due.pop_front();
                    levels_checked++;
                    if (want.wrap)
                        wraps_seen++;
                    if (level.energy_db !== want.db || level.energy_norm !== want.norm ||
                        level.slot_index !== want.slot || level.pass_complete !== want.wrap)
                    begin
                        if (error_count < MAX_REPORTS)
                            $display("level mismatch: expected db %0d norm %0d slot %0d wrap %0b,",
                                     want.db, want.norm, want.slot, want.wrap,
                                     " got db %0d norm %0d slot %0d wrap %0b",
                                     level.energy_db, level.energy_norm,
                                     level.slot_index, level.pass_complete);
                        error_count++;
                    end
                end
            end
            // long hold-off lets the output register fill and back up the input
            if (hold_off_req != 0)
            begin
                stall_left = hold_off_req;
                longest_hold = hold_off_req;
                hold_off_req = 0;
            end
            else if (stall_left == 0 && !quiet && !calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left > 0)
            begin
                level.ready <= 1'b0;
                stall_left--;
            end
            else
                level.ready <= 1'b1;
        end
    end

    initial begin : stimulus
        int                 r;
        int                 k;
        int                 phase;
        int                 flavor;
        int                 count;
        int                 eff;
        int                 rand_items;
        int                 level_base;
        int                 drain;
        logic [CFG_DATA_W-1:0] wlen;
        logic [CFG_DATA_W-1:0] fdata;
        logic signed [15:0] smp;
        step_row_t          row;

        rst_n        <= 1'b0;
        audio.valid  <= 1'b0;
        audio.sample <= '0;
        cfg.valid    <= 1'b0;
        cfg.index    <= '0;
        cfg.data     <= '0;
        win_len_reg = WLEN_RESET;
        floor_reg   = FLOOR_RESET;
        acc_sq      = '0;
        acc_count   = '0;
        slot_no     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < $size(directed_rows); r++)
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG)
                write_reg(row.idx, row.val[CFG_DATA_W-1:0]);
            else
                send_sample(row.val, row.typed, row.db, row.norm);
        end

        rand_items = 0;
        level_base = levels_predicted;
        phase = 0;
        while (rand_items < RAND_ITEMS || levels_predicted - level_base < MIN_LEVELS)
        begin
            flavor = $urandom_range(0, 5);
            if (phase == 0)
            begin
                // one long window, far above the usual range, fed up to 4 samples past its length
                wlen  = CFG_DATA_W'(256 + $urandom_range(0, 40));
                fdata = 9'd120;
                count = int'(wlen) + $urandom_range(0, 4);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       wlen = '0;
                    7, 8:    wlen = CFG_DATA_W'($urandom_range(9, 40));
                    9:       wlen = CFG_DATA_W'($urandom_range(41, 64));
                    default: wlen = CFG_DATA_W'($urandom_range(1, 8));
                endcase
                case ($urandom_range(0, 5))
                    0:       fdata = 9'd1;
                    1:       fdata = 9'd120;
                    2:       fdata = CFG_DATA_W'($urandom_range(0, 3) << FLOOR_W);
                    default: fdata = CFG_DATA_W'($urandom_range(0, 511));
                endcase
                if (phase == 1)
                    wlen = 9'd1;
                eff = (wlen == 0) ? 1 : int'(wlen);
                count = eff * ((eff > 8) ? $urandom_range(1, 2) : $urandom_range(2, 8))
                        + $urandom_range(0, 3);
                if (phase == 1)
                    count = 40;
            end
            if (phase < 2 || $urandom_range(0, 3) != 0)
                write_reg(CFG_WINDOW_LENGTH, wlen);
            if (phase < 2 || $urandom_range(0, 3) != 0)
                write_reg(CFG_FLOOR_DB, fdata);
            if ($urandom_range(0, 7) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI,
                          CFG_DATA_W'($urandom));
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 1)
            begin
                calm = 1'b1;
                hold_off_req = HOLD_OFF_CYCLES;
            end
            for (k = 0; k < count; k++)
            begin
                case (flavor)
                    0: smp = '0;
                    1: smp = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
                    default:
                    begin
                        case ($urandom_range(0, 7))
                            0:       smp = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
                            1:       smp = '0;
                            2:       smp = 16'($urandom_range(0, 31) - 16);
                            3:       smp = 16'($urandom_range(0, 1023) - 512);
                            default: smp = 16'($urandom);
                        endcase
                    end
                endcase
                send_sample(smp, 1'b0, '0, '0);
                rand_items++;
                if (rand_items >= RAND_ITEMS - QUIET_ITEMS)
                    quiet = 1'b1;
            end
            phase++;
        end

        audio.valid <= 1'b0;
        drain = 0;
        while (levels_due.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (levels_due.size() != 0)
        begin
            $display("%0d expected levels never came out", levels_due.size());
            error_count += levels_due.size();
        end

        $display("run: %0d samples in, %0d levels checked (%0d slot wraps), %0d register writes",
                 samples_sent, levels_checked, wraps_seen, reg_writes);
        $display("run: windows up to %0d samples, output held off once for %0d cycles",
                 max_window, longest_hold);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("timeout with %0d levels outstanding", levels_due.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
sv/awedb_pkg.sv
sv/awedb_if.sv
sv/awedb_ctrl.sv
sv/awedb_dp.sv
sv/audio_window_energy_db_meter.sv
bench/audio_window_energy_db_meter_tb.sv
